@@ rtl/pidcaw_pkg.sv @@
// ----------------------------------------------------------------------------
// pidcaw_pkg
// Shared types and constants for the PID controller with conditional
// integration anti-windup: register map, configuration bundle, sequencer.
// ----------------------------------------------------------------------------
package pidcaw_pkg;

    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ERR_W    = 16;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned DRIVE_W  = 16;
    localparam int unsigned LIMIT_W  = 23;
    localparam int unsigned ACCUM_W  = 24;
    localparam int unsigned PROD_W   = GAIN_W + ACCUM_W;   // 40
    localparam int unsigned SUM_W    = PROD_W + 1;         // 41
    localparam int unsigned FRAC_W   = 8;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_I      = 3'd1;
    localparam logic [2:0] REG_GAIN_D      = 3'd2;
    localparam logic [2:0] REG_DRIVE_MIN   = 3'd3;
    localparam logic [2:0] REG_DRIVE_MAX   = 3'd4;
    localparam logic [2:0] REG_ACCUM_LIMIT = 3'd5;

    // Input item kinds carried on tuser
    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [DRIVE_W-1:0] drive_min;
        logic signed [DRIVE_W-1:0] drive_max;
        logic        [LIMIT_W-1:0] accum_limit;
    } t_cfg;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MULP = 7'b0000010,
        ST_MULD = 7'b0000100,
        ST_PD   = 7'b0001000,
        ST_INTG = 7'b0010000,
        ST_MULI = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

endpackage

@@ rtl/pidcaw_regs.sv @@
// ----------------------------------------------------------------------------
// pidcaw_regs
// APB register file holding the gains, drive limits and integral clamp.
// ----------------------------------------------------------------------------
module pidcaw_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pidcaw_pkg::ADDR_W-1:0]   paddr,
    input  logic [pidcaw_pkg::DATA_W-1:0]   pwdata,
    output logic [pidcaw_pkg::DATA_W-1:0]   prdata,
    output logic                            pready,
    output pidcaw_pkg::t_cfg                o_cfg
);

    pidcaw_pkg::t_cfg r_cfg;
    logic             w_wr;
    logic [2:0]       w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p      <= '0;
            r_cfg.gain_i      <= '0;
            r_cfg.gain_d      <= '0;
            r_cfg.drive_min   <= 16'sh8000;
            r_cfg.drive_max   <= 16'sh7FFF;
            r_cfg.accum_limit <= '1;
        end else if (w_wr) begin
            unique case (w_idx)
                pidcaw_pkg::REG_GAIN_P:      r_cfg.gain_p      <= pwdata[15:0];
                pidcaw_pkg::REG_GAIN_I:      r_cfg.gain_i      <= pwdata[15:0];
                pidcaw_pkg::REG_GAIN_D:      r_cfg.gain_d      <= pwdata[15:0];
                pidcaw_pkg::REG_DRIVE_MIN:   r_cfg.drive_min   <= pwdata[15:0];
                pidcaw_pkg::REG_DRIVE_MAX:   r_cfg.drive_max   <= pwdata[15:0];
                pidcaw_pkg::REG_ACCUM_LIMIT: r_cfg.accum_limit <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            pidcaw_pkg::REG_GAIN_P:      prdata = {16'd0, r_cfg.gain_p};
            pidcaw_pkg::REG_GAIN_I:      prdata = {16'd0, r_cfg.gain_i};
            pidcaw_pkg::REG_GAIN_D:      prdata = {16'd0, r_cfg.gain_d};
            pidcaw_pkg::REG_DRIVE_MIN:   prdata = {16'd0, r_cfg.drive_min};
            pidcaw_pkg::REG_DRIVE_MAX:   prdata = {16'd0, r_cfg.drive_max};
            pidcaw_pkg::REG_ACCUM_LIMIT: prdata = {9'd0, r_cfg.accum_limit};
            default:                     prdata = '0;
        endcase
    end

endmodule

@@ rtl/pid_conditional_antiwindup_core.sv @@
// ----------------------------------------------------------------------------
// pid_conditional_antiwindup_core
// Positional PID with Q8.8 gains and conditional-integration anti-windup,
// built around one shared 16x24 signed multiplier and an accumulator.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tdata: err_value; tuser: op
//  m_*       out        m_tvalid/m_tready  tdata: drive
//  APB       in/out     psel/penable       six 32-bit registers at 4*i
//
//  A compute transaction steps the sequencer through P product, D product,
//  P+D sum, integral update, I product, then the final sum with floor and
//  clamp into the output register. s_tready returns the cycle after, so a
//  new compute transaction is accepted only after the last one is done.
//  A clear transaction clears the integral and previous error, no output.
//  s_tready is high only while the sequencer is idle; a stalled output holds
//  the sequencer in its last step until the pending result is taken.
//  Reset (i_rst_n low, synchronous) clears the integral, previous error,
//  the sequencer and the output valid flag, and loads register defaults.
// ----------------------------------------------------------------------------
module pid_conditional_antiwindup_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] err_value
    input  logic                            s_tuser,   // [0] op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [15:0] drive
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pidcaw_pkg::ADDR_W-1:0]   paddr,
    input  logic [pidcaw_pkg::DATA_W-1:0]   pwdata,
    output logic [pidcaw_pkg::DATA_W-1:0]   prdata,
    output logic                            pready
);

    pidcaw_pkg::t_cfg   w_cfg;
    pidcaw_pkg::t_state r_state, n_state;

    logic signed [15:0] r_err;
    logic signed [16:0] r_diff;
    logic signed [15:0] r_last;
    logic signed [23:0] r_accum;
    logic signed [39:0] r_prod;
    logic signed [40:0] r_acc;
    logic               r_out_valid;
    logic signed [15:0] r_drive;

    logic               w_in_acc;
    logic signed [15:0] w_mul_a;
    logic signed [23:0] w_mul_b;
    logic signed [39:0] w_mul_p;
    logic signed [40:0] w_sum;
    logic signed [40:0] w_max_q;
    logic signed [40:0] w_min_q;
    logic               w_pos, w_neg, w_hold;
    logic signed [24:0] w_int_sum;
    logic signed [24:0] w_lim;
    logic signed [23:0] w_int_next;
    logic signed [32:0] w_q;
    logic signed [32:0] w_q_hi;
    logic signed [32:0] w_q_lo;
    logic signed [32:0] w_clamp_hi;
    logic signed [15:0] w_clamp;
    logic               w_out_free;

    pidcaw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign s_tready   = (r_state == pidcaw_pkg::ST_IDLE);
    assign w_in_acc   = s_tvalid & s_tready;
    assign m_tvalid   = r_out_valid;
    assign m_tdata    = r_drive;
    assign w_out_free = !r_out_valid || m_tready;

    // Shared multiplier operand select
    always_comb begin
        w_mul_a = w_cfg.gain_p;
        w_mul_b = {{8{r_err[15]}}, r_err};
        case (r_state)
            pidcaw_pkg::ST_MULD: begin
                w_mul_a = w_cfg.gain_d;
                w_mul_b = {{7{r_diff[16]}}, r_diff};
            end
            pidcaw_pkg::ST_MULI: begin
                w_mul_a = w_cfg.gain_i;
                w_mul_b = r_accum;
            end
            default: ;
        endcase
    end

    assign w_mul_p = 40'(w_mul_a) * 40'(w_mul_b);
    assign w_sum   = r_acc + {r_prod[39], r_prod};

    // Hold integration while P+D already reaches or passes a limit in the error's direction
    assign w_max_q = {{17{w_cfg.drive_max[15]}}, w_cfg.drive_max, 8'd0};
    assign w_min_q = {{17{w_cfg.drive_min[15]}}, w_cfg.drive_min, 8'd0};
    assign w_pos   = !r_err[15] && (r_err != 16'sd0);
    assign w_neg   = r_err[15];
    assign w_hold  = ((r_acc >= w_max_q) && w_pos) || ((r_acc <= w_min_q) && w_neg);

    assign w_int_sum = {r_accum[23], r_accum} + {{9{r_err[15]}}, r_err};
    assign w_lim     = {2'b00, w_cfg.accum_limit};

    always_comb begin
        if (w_int_sum > w_lim) begin
            w_int_next = w_lim[23:0];
        end else if (w_int_sum < -w_lim) begin
            w_int_next = 24'(-w_lim);
        end else begin
            w_int_next = w_int_sum[23:0];
        end
    end

    // Floor divide by 256, clamp high first so drive_min wins on crossed limits
    assign w_q        = w_sum[40:8];
    assign w_q_hi     = {{17{w_cfg.drive_max[15]}}, w_cfg.drive_max};
    assign w_q_lo     = {{17{w_cfg.drive_min[15]}}, w_cfg.drive_min};
    assign w_clamp_hi = (w_q > w_q_hi) ? w_q_hi : w_q;
    assign w_clamp    = (w_clamp_hi < w_q_lo) ? w_cfg.drive_min : w_clamp_hi[15:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pidcaw_pkg::ST_IDLE: begin
                if (w_in_acc && (s_tuser == pidcaw_pkg::OP_COMPUTE)) begin
                    n_state = pidcaw_pkg::ST_MULP;
                end
            end
            pidcaw_pkg::ST_MULP: n_state = pidcaw_pkg::ST_MULD;
            pidcaw_pkg::ST_MULD: n_state = pidcaw_pkg::ST_PD;
            pidcaw_pkg::ST_PD:   n_state = pidcaw_pkg::ST_INTG;
            pidcaw_pkg::ST_INTG: n_state = pidcaw_pkg::ST_MULI;
            pidcaw_pkg::ST_MULI: n_state = pidcaw_pkg::ST_OUT;
            pidcaw_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = pidcaw_pkg::ST_IDLE;
                end
            end
            default: n_state = pidcaw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidcaw_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_accum     <= '0;
            r_last      <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == pidcaw_pkg::ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                pidcaw_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        if (s_tuser == pidcaw_pkg::OP_CLEAR) begin
                            r_accum <= '0;
                            r_last  <= '0;
                        end else begin
                            r_last <= s_tdata;
                        end
                    end
                end
                pidcaw_pkg::ST_INTG: begin
                    if (!w_hold) begin
                        r_accum <= w_int_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            pidcaw_pkg::ST_IDLE: begin
                r_err  <= s_tdata;
                r_diff <= {s_tdata[15], s_tdata} - {r_last[15], r_last};
            end
            pidcaw_pkg::ST_MULP: r_prod <= w_mul_p;
            pidcaw_pkg::ST_MULD: begin
                r_prod <= w_mul_p;
                r_acc  <= {r_prod[39], r_prod};
            end
            pidcaw_pkg::ST_PD:   r_acc  <= w_sum;
            pidcaw_pkg::ST_MULI: r_prod <= w_mul_p;
            pidcaw_pkg::ST_OUT:  begin
                if (w_out_free) begin
                    r_drive <= w_clamp;
                end
            end
            default: ;
        endcase
        if (r_state == pidcaw_pkg::ST_MULI) begin
            r_acc <= r_acc;
        end
    end

endmodule
